// ===== sv/c3f_pkg.sv =====
// ----------------------------------------------------------------------------
// c3f_pkg
// shared constants and types of the 3x3 image filter core
// ----------------------------------------------------------------------------
`default_nettype none

package c3f_pkg;

   localparam int C3F_MAX_WIDTH    = 1024;
   localparam int C3F_MAX_CHANNELS = 4;

   // register indexes of the csr port
   localparam logic [2:0] REG_KERNEL_TOP   = 3'd0;
   localparam logic [2:0] REG_KERNEL_MID   = 3'd1;
   localparam logic [2:0] REG_KERNEL_BOT   = 3'd2;
   localparam logic [2:0] REG_DIVISOR      = 3'd3;
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;
   localparam logic [2:0] REG_CHANNELS     = 3'd6;

   localparam int DIV_DVD_W  = 25;  // dividend / quotient bits
   localparam int DIV_REM_W  = 17;  // partial remainder bits
   localparam int DIV_VSR_W  = 16;  // divisor bits
   localparam int DIV_STEP_W = 5;

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
      logic [DIV_REM_W-1:0]  rem_init;
      logic [DIV_DVD_W-1:0]  dividend;
      logic [DIV_VSR_W-1:0]  divisor;
   } c3f_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_DVD_W-1:0] quot;
      logic [DIV_REM_W-1:0] rem;
   } c3f_div_rsp_type;

endpackage

`default_nettype wire

// ===== sv/conv3x3_image_filter_core.sv =====
// ----------------------------------------------------------------------------
// conv3x3_image_filter_core
// streaming 3x3 convolution with Q8.8 divide and clamp to 0..255
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_*     in         tuser: kind, tdata: comp0..comp3
//  rsp_*     out        tlast: frame_end, tdata: out0..out3
//  csr_*     in         write enable, register index, write data
//
//  a request that yields a result runs the 25-step position divide, then per
//  channel the 9-tap mac, clamp, 8-step divide and store (the divide is
//  skipped when the clamp decides alone); ignored requests return to idle from
//  the check, requests before the first output from the line update
//  after reset the line memory is cleared while req_tready is low
//  a waiting result sits in the output register while the next request runs
//  reset is synchronous, active high
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_image_filter_core import c3f_pkg::*; #(
   parameter int MAX_WIDTH = C3F_MAX_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // comp0, comp1, comp2, comp3
   input  wire logic        req_tuser,   // kind
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // out0, out1, out2, out3
   output logic             rsp_tlast,   // frame_end
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [23:0] csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // sequencer states
   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_MUL_TOT = 4'd2;
   localparam logic [3:0] ST_MUL_POS = 4'd3;
   localparam logic [3:0] ST_CHECK   = 4'd4;
   localparam logic [3:0] ST_UPDATE  = 4'd5;
   localparam logic [3:0] ST_DIVK    = 4'd6;
   localparam logic [3:0] ST_MAC     = 4'd7;
   localparam logic [3:0] ST_CLAMP   = 4'd8;
   localparam logic [3:0] ST_DIVC    = 4'd9;
   localparam logic [3:0] ST_STORE   = 4'd10;
   localparam logic [3:0] ST_OUT     = 4'd11;

   // configuration registers
   logic [23:0] kern_top_ff, kern_mid_ff, kern_bot_ff;
   logic [15:0] divisor_ff;
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [2:0]  chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kern_top_ff <= 24'h000000;
         kern_mid_ff <= 24'h010000;
         kern_bot_ff <= 24'h000000;
         divisor_ff  <= 16'd256;
         width_ff    <= 11'd640;
         height_ff   <= 13'd480;
         chan_ff     <= 3'd3;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_KERNEL_TOP:   kern_top_ff <= csr_wdata;
            REG_KERNEL_MID:   kern_mid_ff <= csr_wdata;
            REG_KERNEL_BOT:   kern_bot_ff <= csr_wdata;
            REG_DIVISOR:      divisor_ff  <= csr_wdata[15:0];
            REG_IMAGE_WIDTH:  width_ff    <= csr_wdata[10:0];
            REG_IMAGE_HEIGHT: height_ff   <= csr_wdata[12:0];
            REG_CHANNELS:     chan_ff     <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // effective geometry, out-of-range values pinned
   logic [10:0] w_eff;
   logic [12:0] h_eff;
   logic [2:0]  nch_eff;

   always_comb begin
      if (width_ff < 11'd3) begin
         w_eff = 11'd3;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = 11'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff < 13'd3) ? 13'd3 : height_ff;
      if (chan_ff == 3'd0) begin
         nch_eff = 3'd1;
      end else if (32'(chan_ff) > C3F_MAX_CHANNELS) begin
         nch_eff = 3'(C3F_MAX_CHANNELS);
      end else begin
         nch_eff = chan_ff;
      end
   end

   // sequencer and datapath registers
   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic [AW-1:0]      col_ff, col_in;
   logic [13:0]        row_ff, row_in;
   logic [23:0]        total_ff, total_in;
   logic [24:0]        s_ff, s_in;
   logic               kind_ff, kind_in;
   logic [31:0]        sample_ff, sample_in;
   logic [31:0]        win_ff [3][3];
   logic [31:0]        win_in [3][3];
   logic               last_ff, last_in;
   logic               row0_ff, row0_in, rowl_ff, rowl_in;
   logic               col0_ff, col0_in, coll_ff, coll_in;
   logic [1:0]         tap_r_ff, tap_r_in, tap_c_ff, tap_c_in;
   logic [1:0]         ch_ff, ch_in;
   logic signed [20:0] acc_ff, acc_in;
   logic [7:0]         res_ff [4];
   logic [7:0]         res_in [4];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   // shared multiplier for frame size and stream position
   logic [13:0] mul_a;
   logic [24:0] mul_p;
   assign mul_a = (state_ff == ST_MUL_TOT) ? {1'b0, h_eff} : row_ff;
   assign mul_p = 25'(mul_a) * 25'(w_eff);

   // line memory: low word is the last row, high word the row before
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [63:0]   mem_wdata;
   logic [63:0]   mem_rdata;

   c3f_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (col_ff),
      .rd_data (mem_rdata)
   );

   assign mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_UPDATE);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : col_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? 64'd0 : {mem_rdata[31:0], sample_ff};

   // shared divider
   c3f_div_req_type div_req;
   c3f_div_rsp_type div_rsp;

   c3f_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // mac operands
   logic [23:0]        kern_row;
   logic [7:0]         coef;
   logic [31:0]        win_word;
   logic [7:0]         pix;
   logic signed [16:0] prod;
   logic               tap_skip;
   logic [24:0]        k_pos;
   logic               out_due;

   always_comb begin
      unique case (tap_r_ff)
         2'd0:    kern_row = kern_top_ff;
         2'd1:    kern_row = kern_mid_ff;
         default: kern_row = kern_bot_ff;
      endcase
      unique case (tap_c_ff)
         2'd0:    coef = kern_row[7:0];
         2'd1:    coef = kern_row[15:8];
         default: coef = kern_row[23:16];
      endcase
      win_word = win_ff[tap_r_ff][tap_c_ff];
      pix      = win_word[8*ch_ff +: 8];
      prod     = $signed(coef) * $signed({1'b0, pix});
      // taps that fall outside the image
      tap_skip = (tap_r_ff == 2'd0 && row0_ff) || (tap_r_ff == 2'd2 && rowl_ff) ||
                 (tap_c_ff == 2'd0 && col0_ff) || (tap_c_ff == 2'd2 && coll_ff);
      // position of the output pixel in the frame
      k_pos    = s_ff - 25'(w_eff) - 25'd1;
      out_due  = s_ff >= 25'(w_eff) + 25'd1;
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      total_in     = total_ff;
      s_in         = s_ff;
      kind_in      = kind_ff;
      sample_in    = sample_ff;
      win_in       = win_ff;
      last_in      = last_ff;
      row0_in      = row0_ff;
      rowl_in      = rowl_ff;
      col0_in      = col0_ff;
      coll_in      = coll_ff;
      tap_r_in     = tap_r_ff;
      tap_c_in     = tap_c_ff;
      ch_in        = ch_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      div_req          = '0;
      div_req.divisor  = divisor_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (32'(clr_addr_ff) == MAX_WIDTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               sample_in = req_tdata;
               state_in  = ST_MUL_TOT;
            end
         end
         ST_MUL_TOT: begin
            total_in = mul_p[23:0];
            state_in = ST_MUL_POS;
         end
         ST_MUL_POS: begin
            s_in     = mul_p + 25'(col_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // drain before the frame is complete is ignored
            if (s_ff < 25'(total_ff) && kind_ff) begin
               state_in = ST_IDLE;
            end else begin
               if (s_ff >= 25'(total_ff)) begin
                  sample_in = '0;
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            for (int r = 0; r < 3; r++) begin
               win_in[r][0] = win_ff[r][1];
               win_in[r][1] = win_ff[r][2];
            end
            win_in[0][2] = mem_rdata[63:32];
            win_in[1][2] = mem_rdata[31:0];
            win_in[2][2] = sample_ff;
            if (32'(col_ff) + 32'd1 >= 32'(w_eff)) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            last_in  = k_pos >= 25'(total_ff) - 25'd1;
            tap_r_in = '0;
            tap_c_in = '0;
            ch_in    = '0;
            acc_in   = '0;
            for (int n = 0; n < 4; n++) begin
               res_in[n] = '0;
            end
            if (out_due) begin
               if (k_pos >= 25'(total_ff) - 25'd1) begin
                  // frame done, next request starts a new frame
                  col_in = '0;
                  row_in = '0;
               end
               div_req.start    = 1'b1;
               div_req.steps    = DIV_STEP_W'(DIV_DVD_W);
               div_req.rem_init = '0;
               div_req.dividend = k_pos;
               div_req.divisor  = DIV_VSR_W'(w_eff);
               state_in = ST_DIVK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVK: begin
            div_req.divisor = DIV_VSR_W'(w_eff);
            if (div_rsp.done) begin
               row0_in  = div_rsp.quot == '0;
               rowl_in  = div_rsp.quot >= 25'(h_eff) - 25'd1;
               col0_in  = div_rsp.rem == '0;
               coll_in  = div_rsp.rem >= 17'(w_eff) - 17'd1;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (!tap_skip) begin
               acc_in = acc_ff + 21'(prod);
            end
            if (tap_c_ff == 2'd2) begin
               tap_c_in = '0;
               tap_r_in = tap_r_ff + 1'b1;
               if (tap_r_ff == 2'd2) begin
                  state_in = ST_CLAMP;
               end
            end else begin
               tap_c_in = tap_c_ff + 1'b1;
            end
         end
         ST_CLAMP: begin
            priority if (acc_ff <= 21'sd0) begin
               res_in[ch_ff] = 8'd0;
               state_in      = ST_STORE;
            end else if (acc_ff >= $signed({5'b0, divisor_ff})) begin
               // quotient at least 256, zero divisor lands here too
               res_in[ch_ff] = 8'd255;
               state_in      = ST_STORE;
            end else begin
               div_req.start    = 1'b1;
               div_req.steps    = DIV_STEP_W'(8);
               div_req.rem_init = 17'(acc_ff[15:0]);
               div_req.dividend = '0;
               state_in         = ST_DIVC;
            end
         end
         ST_DIVC: begin
            if (div_rsp.done) begin
               res_in[ch_ff] = div_rsp.quot[7:0];
               state_in      = ST_STORE;
            end
         end
         ST_STORE: begin
            if (3'(ch_ff) + 3'd1 < nch_eff) begin
               ch_in    = ch_ff + 1'b1;
               tap_r_in = '0;
               tap_c_in = '0;
               acc_in   = '0;
               state_in = ST_MAC;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
      total_ff    <= total_in;
      s_ff        <= s_in;
      kind_ff     <= kind_in;
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      row0_ff     <= row0_in;
      rowl_ff     <= rowl_in;
      col0_ff     <= col0_in;
      coll_ff     <= coll_in;
      tap_r_ff    <= tap_r_in;
      tap_c_ff    <= tap_c_in;
      ch_ff       <= ch_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/c3f_divider.sv =====
// ----------------------------------------------------------------------------
// c3f_divider
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_divider import c3f_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire c3f_div_req_type req,
   output c3f_div_rsp_type      rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_REM_W-1:0]  rem_ff, rem_in;
   logic [DIV_DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_DVD_W-1:0]  quot_ff, quot_in;
   logic [DIV_REM_W-1:0]  trial;

   always_comb begin
      trial   = {rem_ff[DIV_REM_W-2:0], dvd_ff[DIV_DVD_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         rem_in  = req.rem_init;
         dvd_in  = req.dividend;
         quot_in = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_DVD_W-2:0], 1'b0};
         if (trial >= DIV_REM_W'(req.divisor)) begin
            rem_in  = trial - DIV_REM_W'(req.divisor);
            quot_in = {quot_ff[DIV_DVD_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[DIV_DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

`default_nettype wire

// ===== sv/c3f_line_mem.sv =====
// ----------------------------------------------------------------------------
// c3f_line_mem
// the two line stores side by side in one memory, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_line_mem import c3f_pkg::*; #(
   parameter int DEPTH = C3F_MAX_WIDTH,
   parameter int AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [63:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [63:0]        rd_data
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/c3f_checker.sv =====
// ----------------------------------------------------------------------------
// c3f_checker
// port-level checks of the 3x3 image filter core
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // memory clear keeps the block busy after reset
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during line memory clear");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind conv3x3_image_filter_core c3f_checker u_c3f_checker (.*);

`default_nettype wire
